### rtl/prc_pkg.sv
// Shared constants for the plane relative coordinate pipeline.
package prc_pkg;

	localparam int FRAC_BITS = 16;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NO_DEN  = 2'd1,
		STATUS_NO_EDGE = 2'd2
	} status_t;

endpackage

### rtl/prc_div.sv
// Pipelined restoring divider with a saturated, signed, fixed-width quotient.
module prc_div #(
	parameter int NW = 65,
	parameter int DW = 48,
	parameter int QW = 32,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num_mag,
	input  logic          num_neg,
	input  logic [DW-1:0] den_mag,
	input  logic          den_neg,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quot,
	output logic [SW-1:0] side_out
);
	localparam int HW = NW - QW;
	localparam int CW = (HW > DW) ? HW : DW;

	logic          v_s    [0:QW];
	logic [DW-1:0] rem_s  [0:QW];
	logic [QW-1:0] q_s    [0:QW];
	logic [QW-1:0] low_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic          ovf_s  [0:QW];
	logic          neg_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];

	logic [CW-1:0] hi_ext;
	logic [CW-1:0] den_ext;

	assign hi_ext  = CW'(num_mag[NW-1:QW]);
	assign den_ext = CW'(den_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= hi_ext[DW-1:0];
			q_s[0]    <= '0;
			low_s[0]  <= num_mag[QW-1:0];
			den_s[0]  <= den_mag;
			ovf_s[0]  <= (hi_ext >= den_ext);
			neg_s[0]  <= num_neg ^ den_neg;
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        take;

		assign trial = {rem_s[i], low_s[i][QW-1-i]};
		assign diff  = trial - {1'b0, den_s[i]};
		assign take  = (trial >= {1'b0, den_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= take ? diff[DW-1:0] : trial[DW-1:0];
				q_s[i+1]    <= {q_s[i][QW-2:0], take};
				low_s[i+1]  <= low_s[i];
				den_s[i+1]  <= den_s[i];
				ovf_s[i+1]  <= ovf_s[i];
				neg_s[i+1]  <= neg_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	logic [QW-1:0] lim;
	logic [QW-1:0] mag;
	logic [QW-1:0] res;

	always_comb begin
		lim = neg_s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		mag = (ovf_s[QW] || (q_s[QW] > lim)) ? lim : q_s[QW];
		res = neg_s[QW] ? (~mag + 1'b1) : mag;
	end

	logic          v_sq;
	logic [QW-1:0] quot_sq;
	logic [SW-1:0] side_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq <= 1'b0;
		end else if (en) begin
			v_sq <= v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_sq <= res;
			side_sq <= side_s[QW];
		end
	end

	assign out_valid = v_sq;
	assign quot      = quot_sq;
	assign side_out  = side_sq;

endmodule

### rtl/plane_relative_coords_core.sv
// Top level: plane relative coordinates by Cramer's rule, fully pipelined.
// Two dividers each resolve one quotient bit per stage.
// Throughput is one word per cycle; a held output word stalls the whole pipeline.
// Reset clears only the valid bits; data registers are not reset.
module plane_relative_coords_core #(
	parameter int COMPONENT_BITS = 24,
	parameter int COORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// delta_x/y/z, first_edge_x/y/z, second_edge_x/y/z, den_xy, den_xz, den_yz
	input  logic [((15*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// coord_first, coord_second, status
	output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_tdata
);
	import prc_pkg::*;

	localparam int C   = COMPONENT_BITS;
	localparam int R   = COORD_BITS;
	localparam int DNW = 2 * C;
	localparam int N1A = 2 * C + 1 + FRAC_BITS;
	localparam int N1W = (N1A > R + 1) ? N1A : R + 1;
	localparam int N2W = R + C + 1;
	localparam int SW1 = 2 + 3 * C;
	localparam int SW2 = 2 + R;
	localparam int OW  = ((2*R+2+7)/8)*8;

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [C-1:0]   dx, dy, dz, e1x, e1y, e1z, e2x, e2y, e2z;
	logic signed [DNW-1:0] dxy, dxz, dyz;

	assign dx  = s_tdata[0*C +: C];
	assign dy  = s_tdata[1*C +: C];
	assign dz  = s_tdata[2*C +: C];
	assign e1x = s_tdata[3*C +: C];
	assign e1y = s_tdata[4*C +: C];
	assign e1z = s_tdata[5*C +: C];
	assign e2x = s_tdata[6*C +: C];
	assign e2y = s_tdata[7*C +: C];
	assign e2z = s_tdata[8*C +: C];
	assign dxy = s_tdata[9*C +: DNW];
	assign dxz = s_tdata[9*C+DNW +: DNW];
	assign dyz = s_tdata[9*C+2*DNW +: DNW];

	logic signed [C-1:0]   ma, mb, mc, md, e2k, dk, e1k;
	logic signed [DNW-1:0] den_sel;
	status_t               st;

	always_comb begin
		if (dxy != '0) begin
			ma = dx; mb = e2y; mc = e2x; md = dy; den_sel = dxy;
		end else if (dxz != '0) begin
			ma = dx; mb = e2z; mc = e2x; md = dz; den_sel = dxz;
		end else begin
			ma = dy; mb = e2z; mc = e2y; md = dz; den_sel = dyz;
		end
		if (e2x != '0) begin
			e2k = e2x; dk = dx; e1k = e1x;
		end else if (e2y != '0) begin
			e2k = e2y; dk = dy; e1k = e1y;
		end else begin
			e2k = e2z; dk = dz; e1k = e1z;
		end
		if (dxy == '0 && dxz == '0 && dyz == '0) begin
			st = STATUS_NO_DEN;
		end else if (e2x == '0 && e2y == '0 && e2z == '0) begin
			st = STATUS_NO_EDGE;
		end else begin
			st = STATUS_OK;
		end
	end

	logic                  v_s1;
	logic signed [DNW-1:0] p0_s1, p1_s1, den_s1;
	logic [SW1-1:0]        side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1   <= ma * mb;
			p1_s1   <= mc * md;
			den_s1  <= den_sel;
			side_s1 <= {e1k, dk, e2k, st};
		end
	end

	logic signed [DNW:0] n1;
	logic [DNW:0]        n1_abs;
	logic [DNW-1:0]      den_abs;

	always_comb begin
		n1      = {p0_s1[DNW-1], p0_s1} - {p1_s1[DNW-1], p1_s1};
		n1_abs  = n1[DNW] ? (~n1 + 1'b1) : n1;
		den_abs = den_s1[DNW-1] ? (~den_s1 + 1'b1) : den_s1;
	end

	logic           v_s2, neg1_s2, dneg_s2;
	logic [N1W-1:0] num1_s2;
	logic [DNW-1:0] den1_s2;
	logic [SW1-1:0] side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s2 <= N1W'({n1_abs, {FRAC_BITS{1'b0}}});
			neg1_s2 <= n1[DNW];
			den1_s2 <= den_abs;
			dneg_s2 <= den_s1[DNW-1];
			side_s2 <= side_s1;
		end
	end

	logic           v_d1;
	logic [R-1:0]   a_d1;
	logic [SW1-1:0] side_d1;

	prc_div #(.NW(N1W), .DW(DNW), .QW(R), .SW(SW1)) u_div_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num_mag  (num1_s2),
		.num_neg  (neg1_s2),
		.den_mag  (den1_s2),
		.den_neg  (dneg_s2),
		.side_in  (side_s2),
		.out_valid(v_d1),
		.quot     (a_d1),
		.side_out (side_d1)
	);

	logic                  v_s3;
	logic signed [R+C-1:0] prod_s3;
	logic signed [C-1:0]   dk_s3, e2k_s3;
	logic [R-1:0]          a_s3;
	logic [1:0]            st_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= $signed(a_d1) * $signed(side_d1[2+2*C +: C]);
			dk_s3   <= side_d1[2+C +: C];
			e2k_s3  <= side_d1[2 +: C];
			st_s3   <= side_d1[1:0];
			a_s3    <= a_d1;
		end
	end

	logic signed [R+C:0] dk_sh, n2;
	logic [R+C:0]        n2_abs;
	logic [C-1:0]        e2k_abs;

	always_comb begin
		dk_sh   = (R+C+1)'(dk_s3) <<< FRAC_BITS;
		n2      = dk_sh - {prod_s3[R+C-1], prod_s3};
		n2_abs  = n2[R+C] ? (~n2 + 1'b1) : n2;
		e2k_abs = e2k_s3[C-1] ? (~e2k_s3 + 1'b1) : e2k_s3;
	end

	logic           v_s4, neg2_s4, eneg_s4;
	logic [N2W-1:0] num2_s4;
	logic [C-1:0]   den2_s4;
	logic [SW2-1:0] side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num2_s4 <= n2_abs;
			neg2_s4 <= n2[R+C];
			den2_s4 <= e2k_abs;
			eneg_s4 <= e2k_s3[C-1];
			side_s4 <= {a_s3, st_s3};
		end
	end

	logic           v_d2;
	logic [R-1:0]   b_d2;
	logic [SW2-1:0] side_d2;

	prc_div #(.NW(N2W), .DW(C), .QW(R), .SW(SW2)) u_div_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num_mag  (num2_s4),
		.num_neg  (neg2_s4),
		.den_mag  (den2_s4),
		.den_neg  (eneg_s4),
		.side_in  (side_s4),
		.out_valid(v_d2),
		.quot     (b_d2),
		.side_out (side_d2)
	);

	logic          v_s5;
	logic [OW-1:0] data_s5;
	logic          ok;

	assign ok = (side_d2[1:0] == STATUS_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s5 <= OW'({side_d2[1:0],
				ok ? b_d2 : {R{1'b0}},
				ok ? side_d2[2 +: R] : {R{1'b0}}});
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = data_s5;

endmodule
